/* rtl/tgc_pkg.sv */
// Shared types, codes, tile tables and helper functions of the tile grid collapse engine.
package tgc_pkg;

   localparam int DEF_MAX_SIDE = 16;
   localparam int NUM_TILES = 16;
   localparam int SIDE_LIMIT = 16;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_PLACE = 2'd1;
   localparam logic [1:0] CMD_STEP = 2'd2;
   localparam logic [1:0] CMD_READ = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NO_OPEN = 2'd1;
   localparam logic [1:0] ST_CONTRA = 2'd2;
   localparam logic [1:0] ST_OUTSIDE = 2'd3;

   localparam logic [1:0] DIR_N = 2'd0;
   localparam logic [1:0] DIR_E = 2'd1;
   localparam logic [1:0] DIR_S = 2'd2;
   localparam logic [1:0] DIR_W = 2'd3;

   typedef logic [NUM_TILES-1:0] mask_type;

   typedef struct packed {
      logic collapsed;
      logic [3:0] tile;
      mask_type options;
   } cell_type;

   // Allowed-neighbor masks for north, east, south and west.
   localparam mask_type WITH_MASK [4] = '{16'hACE0, 16'h76C0, 16'h6B60, 16'hBF00};

   // Connection bits per tile: bit 0 north, bit 1 east, bit 2 south, bit 3 west.
   localparam logic [3:0] TILE_DIRS [16] = '{
      4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h5, 4'hD, 4'hC,
      4'h3, 4'hB, 4'hE, 4'h7, 4'hA, 4'hF, 4'h9, 4'h6
   };

   function automatic mask_type dir_mask(input logic [3:0] t, input logic [1:0] d);
      mask_type m;
      m = WITH_MASK[d];
      if (!TILE_DIRS[t][d]) begin
         m = ~m;
      end
      return m;
   endfunction

   function automatic logic [4:0] pop_count(input mask_type m);
      logic [4:0] n;
      n = '0;
      for (int i = 0; i < NUM_TILES; i++) begin
         n = n + 5'(m[i]);
      end
      return n;
   endfunction

endpackage

/* rtl/tile_grid_collapse_engine_unit.sv */
// Top level: command sequencer of the tile grid collapse engine around the cell memory.
//
// A command beat is taken at a clock edge where start is high and busy is low.
// Every command returns exactly one result beat, marked by rsp_valid for one
// cycle; the receiver cannot hold it off, and busy stays high until the result
// register is loaded, so a new command may start while a result is shown.
// The grid size register is written through csr_we and csr_wdata; the user must
// do so only while idle, which the block itself does not enforce.
// Command sequences, shaped by the single read port of the cell memory:
//   place or read outside the grid: the result is registered from the idle state.
//   read: one cell read, then the result. place: center read, center write, then a
//   read and a write per neighbor. clear: every cell is written, one cell per cycle.
//   step: scan of the side*side cells, the serial remainder unit, the rank search,
//   then the place sequence from the center write on.
// After reset the block runs a clearing pass over all MAX_SIDE*MAX_SIDE cells with
// busy high and returns no result for it; the grid size resets to 5.
module tile_grid_collapse_engine_unit #(
   parameter int MAX_SIDE = tgc_pkg::DEF_MAX_SIDE
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [4:0] csr_wdata,
   input  logic start,
   output logic busy,
   input  logic [1:0] req_cmd,
   input  logic [3:0] req_row,
   input  logic [3:0] req_col,
   input  logic [3:0] req_tile,
   input  logic [31:0] req_rnd,
   output logic rsp_valid,
   output logic [1:0] rsp_status,
   output logic [3:0] rsp_cell_row,
   output logic [3:0] rsp_cell_col,
   output logic [3:0] rsp_cell_tile,
   output logic rsp_cell_collapsed,
   output tgc_pkg::mask_type rsp_cell_options
);
   import tgc_pkg::*;

   localparam int CELLS = MAX_SIDE * MAX_SIDE;
   localparam int AW = $clog2(CELLS);
   localparam logic [4:0] SIDE_CAP = 5'((MAX_SIDE < SIDE_LIMIT) ? MAX_SIDE : SIDE_LIMIT);

   localparam logic [3:0] S_CLR = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_CTR = 4'd2;
   localparam logic [3:0] S_SCAN = 4'd3;
   localparam logic [3:0] S_MOD = 4'd4;
   localparam logic [3:0] S_PICK = 4'd5;
   localparam logic [3:0] S_FIX = 4'd6;
   localparam logic [3:0] S_NRD = 4'd7;
   localparam logic [3:0] S_NWR = 4'd8;

   function automatic logic [AW-1:0] cell_index(input logic [3:0] r, input logic [3:0] c);
      return AW'(int'(r) * MAX_SIDE + int'(c));
   endfunction

   logic [3:0] state_ff, state_in;
   logic [4:0] gs_ff, gs_in;
   logic [AW-1:0] clr_idx_ff, clr_idx_in;
   logic clr_cmd_ff, clr_cmd_in;
   logic [1:0] cmd_ff, cmd_in;
   logic [3:0] cr_ff, cr_in, cc_ff, cc_in, tile_ff, tile_in;
   mask_type mask_ff, mask_in;
   logic [31:0] rnd_ff, rnd_in;
   logic [3:0] sr_ff, sr_in, sc_ff, sc_in;
   logic issue_done_ff, issue_done_in;
   logic sv_ff, sv_in;
   logic [3:0] pr_ff, pr_in, pc_ff, pc_in;
   logic [4:0] best_ff, best_in;
   logic [3:0] br_ff, br_in, bc_ff, bc_in;
   mask_type bmask_ff, bmask_in;
   logic found_ff, found_in;
   logic [1:0] d_ff, d_in;
   logic [3:0] rank_ff, rank_in, t_ff, t_in, seen_ff, seen_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [3:0] rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in, rsp_tile_ff, rsp_tile_in;
   logic rsp_coll_ff, rsp_coll_in;
   mask_type rsp_opt_ff, rsp_opt_in;

   logic [4:0] side;
   logic [AW-1:0] rd_addr, wr_addr;
   logic wr_en;
   cell_type rd_data, wr_data;
   logic mod_start, mod_done;
   logic [4:0] mod_rem;
   logic nb_ok;
   logic [3:0] nb_row, nb_col;
   logic [AW-1:0] nb_idx;

   assign side = (gs_ff > SIDE_CAP) ? SIDE_CAP : gs_ff;

   always_comb begin
      nb_ok = 1'b0;
      nb_row = cr_ff;
      nb_col = cc_ff;
      unique case (d_ff)
         DIR_N: begin
            nb_ok = (cr_ff != 4'd0);
            nb_row = cr_ff - 4'd1;
         end
         DIR_E: begin
            nb_ok = ({1'b0, cc_ff} + 5'd1 < side);
            nb_col = cc_ff + 4'd1;
         end
         DIR_S: begin
            nb_ok = ({1'b0, cr_ff} + 5'd1 < side);
            nb_row = cr_ff + 4'd1;
         end
         default: begin
            nb_ok = (cc_ff != 4'd0);
            nb_col = cc_ff - 4'd1;
         end
      endcase
   end

   assign nb_idx = cell_index(nb_row, nb_col);

   tgc_store #(.DEPTH(CELLS), .AW(AW)) u_store (
      .clock(clock),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

   tgc_mod u_mod (
      .clock(clock),
      .reset(reset),
      .start(mod_start),
      .dividend(rnd_ff),
      .divisor(best_ff),
      .done(mod_done),
      .remainder(mod_rem)
   );

   always_comb begin
      state_in = state_ff;
      gs_in = gs_ff;
      clr_idx_in = clr_idx_ff;
      clr_cmd_in = clr_cmd_ff;
      cmd_in = cmd_ff;
      cr_in = cr_ff;
      cc_in = cc_ff;
      tile_in = tile_ff;
      mask_in = mask_ff;
      rnd_in = rnd_ff;
      sr_in = sr_ff;
      sc_in = sc_ff;
      issue_done_in = issue_done_ff;
      sv_in = 1'b0;
      pr_in = sr_ff;
      pc_in = sc_ff;
      best_in = best_ff;
      br_in = br_ff;
      bc_in = bc_ff;
      bmask_in = bmask_ff;
      found_in = found_ff;
      d_in = d_ff;
      rank_in = rank_ff;
      t_in = t_ff;
      seen_in = seen_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_row_in = rsp_row_ff;
      rsp_col_in = rsp_col_ff;
      rsp_tile_in = rsp_tile_ff;
      rsp_coll_in = rsp_coll_ff;
      rsp_opt_in = rsp_opt_ff;
      rd_addr = cell_index(req_row, req_col);
      wr_en = 1'b0;
      wr_addr = cell_index(cr_ff, cc_ff);
      wr_data = '{collapsed: 1'b1, tile: tile_ff, options: mask_ff};
      mod_start = 1'b0;

      if (csr_we && csr_wdata != 5'd0) begin
         gs_in = csr_wdata;
      end

      unique case (state_ff)
         S_CLR: begin
            wr_en = 1'b1;
            wr_addr = clr_idx_ff;
            wr_data = '{collapsed: 1'b0, tile: 4'd0, options: '1};
            clr_idx_in = clr_idx_ff + AW'(1);
            if (clr_idx_ff == AW'(CELLS - 1)) begin
               state_in = S_IDLE;
               if (clr_cmd_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = ST_OK;
                  rsp_row_in = '0;
                  rsp_col_in = '0;
                  rsp_tile_in = '0;
                  rsp_coll_in = 1'b0;
                  rsp_opt_in = '0;
               end
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd_in = req_cmd;
               cr_in = req_row;
               cc_in = req_col;
               tile_in = req_tile;
               rnd_in = req_rnd;
               unique case (req_cmd)
                  CMD_CLEAR: begin
                     clr_idx_in = '0;
                     clr_cmd_in = 1'b1;
                     state_in = S_CLR;
                  end
                  CMD_STEP: begin
                     sr_in = '0;
                     sc_in = '0;
                     issue_done_in = 1'b0;
                     best_in = 5'(NUM_TILES + 1);
                     found_in = 1'b0;
                     br_in = '0;
                     bc_in = '0;
                     state_in = S_SCAN;
                  end
                  default: begin
                     if ({1'b0, req_row} >= side || {1'b0, req_col} >= side) begin
                        rsp_valid_in = 1'b1;
                        rsp_status_in = ST_OUTSIDE;
                        rsp_row_in = req_row;
                        rsp_col_in = req_col;
                        rsp_tile_in = '0;
                        rsp_coll_in = 1'b0;
                        rsp_opt_in = '0;
                     end else begin
                        state_in = S_CTR;
                     end
                  end
               endcase
            end
         end
         S_CTR: begin
            mask_in = rd_data.options;
            if (cmd_ff == CMD_READ) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = ST_OK;
               rsp_row_in = cr_ff;
               rsp_col_in = cc_ff;
               rsp_tile_in = rd_data.collapsed ? rd_data.tile : 4'd0;
               rsp_coll_in = rd_data.collapsed;
               rsp_opt_in = rd_data.options;
               state_in = S_IDLE;
            end else begin
               state_in = S_FIX;
            end
         end
         S_SCAN: begin
            // One read is issued per cycle; its data is judged in the next cycle.
            rd_addr = cell_index(sr_ff, sc_ff);
            if (sv_ff && !rd_data.collapsed && pop_count(rd_data.options) < best_ff) begin
               best_in = pop_count(rd_data.options);
               br_in = pr_ff;
               bc_in = pc_ff;
               bmask_in = rd_data.options;
               found_in = 1'b1;
            end
            if (!issue_done_ff) begin
               sv_in = 1'b1;
               if ({1'b0, sc_ff} + 5'd1 >= side) begin
                  sc_in = '0;
                  sr_in = sr_ff + 4'd1;
                  if ({1'b0, sr_ff} + 5'd1 >= side) begin
                     issue_done_in = 1'b1;
                  end
               end else begin
                  sc_in = sc_ff + 4'd1;
               end
            end else if (!sv_ff) begin
               if (!found_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = ST_NO_OPEN;
                  rsp_row_in = '0;
                  rsp_col_in = '0;
                  rsp_tile_in = '0;
                  rsp_coll_in = 1'b0;
                  rsp_opt_in = '0;
                  state_in = S_IDLE;
               end else if (best_ff == 5'd0) begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = ST_CONTRA;
                  rsp_row_in = br_ff;
                  rsp_col_in = bc_ff;
                  rsp_tile_in = '0;
                  rsp_coll_in = 1'b0;
                  rsp_opt_in = '0;
                  state_in = S_IDLE;
               end else begin
                  cr_in = br_ff;
                  cc_in = bc_ff;
                  mask_in = bmask_ff;
                  mod_start = 1'b1;
                  state_in = S_MOD;
               end
            end
         end
         S_MOD: begin
            if (mod_done) begin
               rank_in = mod_rem[3:0];
               t_in = '0;
               seen_in = '0;
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            // The rank is below the set-bit count, so the search always ends.
            if (mask_ff[t_ff]) begin
               if (seen_ff == rank_ff) begin
                  tile_in = t_ff;
                  state_in = S_FIX;
               end else begin
                  seen_in = seen_ff + 4'd1;
               end
            end
            t_in = t_ff + 4'd1;
         end
         S_FIX: begin
            wr_en = 1'b1;
            d_in = DIR_N;
            state_in = S_NRD;
         end
         S_NRD: begin
            rd_addr = nb_idx;
            if (nb_ok) begin
               state_in = S_NWR;
            end else if (d_ff == DIR_W) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = ST_OK;
               rsp_row_in = cr_ff;
               rsp_col_in = cc_ff;
               rsp_tile_in = tile_ff;
               rsp_coll_in = 1'b1;
               rsp_opt_in = mask_ff;
               state_in = S_IDLE;
            end else begin
               d_in = d_ff + 2'd1;
            end
         end
         S_NWR: begin
            // Neighbors are distinct cells, so no read here overlaps a pending write.
            wr_addr = nb_idx;
            wr_en = !rd_data.collapsed;
            wr_data = '{collapsed: 1'b0, tile: rd_data.tile,
                        options: rd_data.options & dir_mask(tile_ff, d_ff)};
            if (d_ff == DIR_W) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = ST_OK;
               rsp_row_in = cr_ff;
               rsp_col_in = cc_ff;
               rsp_tile_in = tile_ff;
               rsp_coll_in = 1'b1;
               rsp_opt_in = mask_ff;
               state_in = S_IDLE;
            end else begin
               d_in = d_ff + 2'd1;
               state_in = S_NRD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         gs_ff <= 5'd5;
         clr_idx_ff <= '0;
         clr_cmd_ff <= 1'b0;
         sv_ff <= 1'b0;
         issue_done_ff <= 1'b0;
         found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         gs_ff <= gs_in;
         clr_idx_ff <= clr_idx_in;
         clr_cmd_ff <= clr_cmd_in;
         sv_ff <= sv_in;
         issue_done_ff <= issue_done_in;
         found_ff <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      cr_ff <= cr_in;
      cc_ff <= cc_in;
      tile_ff <= tile_in;
      mask_ff <= mask_in;
      rnd_ff <= rnd_in;
      sr_ff <= sr_in;
      sc_ff <= sc_in;
      pr_ff <= pr_in;
      pc_ff <= pc_in;
      best_ff <= best_in;
      br_ff <= br_in;
      bc_ff <= bc_in;
      bmask_ff <= bmask_in;
      d_ff <= d_in;
      rank_ff <= rank_in;
      t_ff <= t_in;
      seen_ff <= seen_in;
      rsp_status_ff <= rsp_status_in;
      rsp_row_ff <= rsp_row_in;
      rsp_col_ff <= rsp_col_in;
      rsp_tile_ff <= rsp_tile_in;
      rsp_coll_ff <= rsp_coll_in;
      rsp_opt_ff <= rsp_opt_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_cell_row = rsp_row_ff;
   assign rsp_cell_col = rsp_col_ff;
   assign rsp_cell_tile = rsp_tile_ff;
   assign rsp_cell_collapsed = rsp_coll_ff;
   assign rsp_cell_options = rsp_opt_ff;

endmodule

/* rtl/tgc_store.sv */
// Cell memory: one write port and one read port with registered read data.
module tgc_store #(
   parameter int DEPTH = 256,
   parameter int AW = 8
) (
   input  logic clock,
   input  logic [AW-1:0] rd_addr,
   output tgc_pkg::cell_type rd_data,
   input  logic wr_en,
   input  logic [AW-1:0] wr_addr,
   input  tgc_pkg::cell_type wr_data
);
   import tgc_pkg::*;

   cell_type mem [DEPTH];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tgc_mod.sv */
// Serial remainder unit: 32-bit dividend modulo a divisor of 1 to 16, one bit per cycle.
module tgc_mod (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [31:0] dividend,
   input  logic [4:0] divisor,
   output logic done,
   output logic [4:0] remainder
);
   import tgc_pkg::*;

   logic [31:0] dvd_ff, dvd_in;
   logic [4:0] rem_ff, rem_in;
   logic [4:0] div_ff, div_in;
   logic [4:0] cnt_ff, cnt_in;
   logic run_ff, run_in;
   logic done_ff, done_in;
   logic [5:0] trial;

   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      trial = {rem_ff, dvd_ff[31]};
      if (start) begin
         dvd_in = dividend;
         rem_in = '0;
         div_in = divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         // The partial remainder stays below the divisor, so it fits in five bits.
         if (trial >= {1'b0, div_ff}) begin
            rem_in = 5'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[4:0];
         end
         dvd_in = {dvd_ff[30:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done = done_ff;
   assign remainder = rem_ff;

endmodule
